@@ design/lcdmt_pkg.sv @@
`default_nettype none

package lcdmt_pkg;

    // Request commands
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // Display modes as seen in the STAT mode bits
    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_SCAN   = 2'd2,
        MODE_DRAW   = 2'd3
    } mode_t;

    // Source of the read data held in the output stage
    typedef enum logic [1:0] {
        SRC_REG     = 2'd0,
        SRC_BG_PAL  = 2'd1,
        SRC_OBJ_PAL = 2'd2
    } rd_src_t;

    typedef struct packed {
        logic vblank;
        logic stat;
        logic frame;
        logic hblank;
    } flags_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_COLOR_MODE    = 3'd0;
    localparam logic [2:0] CFG_SCAN_CYCLES   = 3'd1;
    localparam logic [2:0] CFG_DRAW_CYCLES   = 3'd2;
    localparam logic [2:0] CFG_LINE_CYCLES   = 3'd3;
    localparam logic [2:0] CFG_VISIBLE_LINES = 3'd4;

    localparam int CFG_DATA_W = 10;

    // Configuration reset values
    localparam logic [8:0] SCAN_CYCLES_RST   = 9'd80;
    localparam logic [8:0] DRAW_CYCLES_RST   = 9'd172;
    localparam logic [9:0] LINE_CYCLES_RST   = 10'd456;
    localparam logic [7:0] VISIBLE_LINES_RST = 8'd144;

    // Register map
    localparam logic [15:0] ADDR_LCDC = 16'hFF40;
    localparam logic [15:0] ADDR_STAT = 16'hFF41;
    localparam logic [15:0] ADDR_SCY  = 16'hFF42;
    localparam logic [15:0] ADDR_SCX  = 16'hFF43;
    localparam logic [15:0] ADDR_LY   = 16'hFF44;
    localparam logic [15:0] ADDR_LYC  = 16'hFF45;
    localparam logic [15:0] ADDR_BGP  = 16'hFF47;
    localparam logic [15:0] ADDR_OBP0 = 16'hFF48;
    localparam logic [15:0] ADDR_OBP1 = 16'hFF49;
    localparam logic [15:0] ADDR_WY   = 16'hFF4A;
    localparam logic [15:0] ADDR_WX   = 16'hFF4B;
    localparam logic [15:0] ADDR_VBK  = 16'hFF4F;
    localparam logic [15:0] ADDR_BCPS = 16'hFF68;
    localparam logic [15:0] ADDR_BCPD = 16'hFF69;
    localparam logic [15:0] ADDR_OCPS = 16'hFF6A;
    localparam logic [15:0] ADDR_OCPD = 16'hFF6B;

    localparam int          PALETTE_BYTES_DEF = 64;
    localparam int          CNT_W             = 17;
    localparam logic [16:0] FRAME_CYCLES      = 17'd70224;
    localparam logic [16:0] COUNT_MAX         = 17'h1FFFF;
    localparam logic [7:0]  LAST_LINE         = 8'd153;
    localparam logic [7:0]  BANK_READ_ONES    = 8'hFE;
    localparam logic [7:0]  STAT_WRITE_MASK   = 8'hF8;
    localparam logic [7:0]  INDEX_AUTO_INC    = 8'h80;
    localparam logic [7:0]  INDEX_ADDR_MASK   = 8'h3F;

    // Palette index after a data write: auto-increment keeps bit 7, clears bit 6
    function automatic logic [7:0] next_index(input logic [7:0] idx);
        logic [7:0] inc;
        inc = idx + 8'd1;
        if ((idx & INDEX_AUTO_INC) != 8'd0)
            next_index = INDEX_AUTO_INC | (inc & INDEX_ADDR_MASK);
        else
            next_index = idx;
    endfunction

endpackage

`default_nettype wire

@@ design/lcdmt_ram.sv @@
`default_nettype none

module lcdmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/lcd_mode_timing_and_status_registers.sv @@
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        request    in_valid / in_ready    command, address, write_data, tick_cycles
// out       result     out_valid / out_ready  read_data, hits, four flags, mode, line
// cfg       write      cfg_write              cfg_index, cfg_data
//
// One request per cycle unless the output stalls; results show the cycle after acceptance.
// All register and timing updates happen at the accepting edge; a palette data read
// issues on the registered port of its palette RAM and the data lands in the output stage.
// The output stage parts the sides: a new request enters while the result is taken.
// Reset clears control state and the per-entry valid bits of both 64-byte palette RAMs
// (an entry not yet written reads zero); no clearing pass is needed.

module lcd_mode_timing_and_status_registers #(
    parameter int PALETTE_BYTES = lcdmt_pkg::PALETTE_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [lcdmt_pkg::CFG_DATA_W-1:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  write_data,
    input  wire logic [7:0]  tick_cycles,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       read_data,
    output logic             read_hit,
    output logic             write_hit,
    output logic             vblank_request,
    output logic             status_request,
    output logic             frame_done,
    output logic             hblank_entered,
    output logic [1:0]       current_mode,
    output logic [7:0]       current_line
);

    localparam int PAL_AW = $clog2(PALETTE_BYTES);

    // Configuration
    logic       color_mode_reg;
    logic [8:0] scan_cycles_reg;
    logic [8:0] draw_cycles_reg;
    logic [9:0] line_cycles_reg;
    logic [7:0] visible_lines_reg;

    // Timing and register state
    logic [lcdmt_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    lcdmt_pkg::mode_t mode_reg, mode_next;
    logic [7:0] line_reg, line_next;
    logic [7:0] ctrl_reg, ctrl_next;
    logic [7:0] stat_reg, stat_next;
    logic [7:0] scy_reg, scy_next;
    logic [7:0] scx_reg, scx_next;
    logic [7:0] lyc_reg, lyc_next;
    logic [7:0] bgp_reg, bgp_next;
    logic [7:0] obp0_reg, obp0_next;
    logic [7:0] obp1_reg, obp1_next;
    logic [7:0] wy_reg, wy_next;
    logic [7:0] wx_reg, wx_next;
    logic       bank_reg, bank_next;
    logic [7:0] bg_idx_reg, bg_idx_next;
    logic [7:0] obj_idx_reg, obj_idx_next;

    // Palette entry valid bits
    logic [PALETTE_BYTES-1:0] bg_vld_reg;
    logic [PALETTE_BYTES-1:0] obj_vld_reg;

    // Output stage
    logic                 out_valid_reg;
    logic [7:0]           rdata_reg, rdata_next;
    logic                 rhit_reg, rhit_next;
    logic                 whit_reg, whit_next;
    lcdmt_pkg::flags_t    flags_reg, flags_next;
    lcdmt_pkg::rd_src_t   src_reg, src_next;
    logic                 ent_vld_reg, ent_vld_next;

    // Palette RAM ports
    logic              bg_we, obj_we, bg_re, obj_re;
    logic [7:0]        bg_q, obj_q;

    logic              in_acc;
    logic [17:0]       sum;
    logic [lcdmt_pkg::CNT_W-1:0] sat;
    logic [9:0]        draw_end;
    logic [7:0]        line_inc;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_acc   = in_valid && in_ready;

    // Saturating counter add
    assign sum      = {1'b0, cnt_reg} + {10'd0, tick_cycles};
    assign sat      = sum[17] ? lcdmt_pkg::COUNT_MAX : sum[16:0];
    assign draw_end = {1'b0, scan_cycles_reg} + {1'b0, draw_cycles_reg};
    assign line_inc = line_reg + 8'd1;

    always_comb
    begin
        cnt_next     = cnt_reg;
        mode_next    = mode_reg;
        line_next    = line_reg;
        ctrl_next    = ctrl_reg;
        stat_next    = stat_reg;
        scy_next     = scy_reg;
        scx_next     = scx_reg;
        lyc_next     = lyc_reg;
        bgp_next     = bgp_reg;
        obp0_next    = obp0_reg;
        obp1_next    = obp1_reg;
        wy_next      = wy_reg;
        wx_next      = wx_reg;
        bank_next    = bank_reg;
        bg_idx_next  = bg_idx_reg;
        obj_idx_next = obj_idx_reg;
        rdata_next   = 8'd0;
        rhit_next    = 1'b0;
        whit_next    = 1'b0;
        flags_next   = '0;
        src_next     = lcdmt_pkg::SRC_REG;
        ent_vld_next = 1'b0;
        bg_we        = 1'b0;
        obj_we       = 1'b0;
        bg_re        = 1'b0;
        obj_re       = 1'b0;

        case (lcdmt_pkg::cmd_t'(command))
            lcdmt_pkg::CMD_TICK:
            begin
                cnt_next = sat;
                if (!ctrl_reg[7])
                begin
                    // Display off: measure frames only
                    if (sat >= lcdmt_pkg::FRAME_CYCLES)
                    begin
                        cnt_next         = sat - lcdmt_pkg::FRAME_CYCLES;
                        flags_next.frame = 1'b1;
                    end
                end
                else
                begin
                    case (mode_reg)
                        lcdmt_pkg::MODE_SCAN:
                        begin
                            if (sat >= {8'd0, scan_cycles_reg})
                                mode_next = lcdmt_pkg::MODE_DRAW;
                        end
                        lcdmt_pkg::MODE_DRAW:
                        begin
                            if (sat >= {7'd0, draw_end})
                            begin
                                mode_next         = lcdmt_pkg::MODE_HBLANK;
                                flags_next.hblank = 1'b1;
                                if (stat_reg[3])
                                    flags_next.stat = 1'b1;
                            end
                        end
                        lcdmt_pkg::MODE_HBLANK:
                        begin
                            if (sat >= {7'd0, line_cycles_reg})
                            begin
                                cnt_next  = sat - {7'd0, line_cycles_reg};
                                line_next = line_inc;
                                if (line_inc == visible_lines_reg)
                                begin
                                    mode_next         = lcdmt_pkg::MODE_VBLANK;
                                    flags_next.vblank = 1'b1;
                                    if (stat_reg[4])
                                        flags_next.stat = 1'b1;
                                end
                                else
                                begin
                                    mode_next = lcdmt_pkg::MODE_SCAN;
                                    if (stat_reg[5])
                                        flags_next.stat = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            if (sat >= {7'd0, line_cycles_reg})
                            begin
                                cnt_next  = sat - {7'd0, line_cycles_reg};
                                line_next = line_inc;
                                if (line_inc > lcdmt_pkg::LAST_LINE)
                                begin
                                    line_next        = 8'd0;
                                    mode_next        = lcdmt_pkg::MODE_SCAN;
                                    flags_next.frame = 1'b1;
                                    if (stat_reg[5])
                                        flags_next.stat = 1'b1;
                                end
                            end
                        end
                    endcase
                    // Refresh mode bits and coincidence
                    stat_next = {stat_reg[7:2], mode_next};
                    if (line_next == lyc_reg)
                    begin
                        stat_next[2] = 1'b1;
                        if (stat_reg[6])
                            flags_next.stat = 1'b1;
                    end
                    else
                    begin
                        stat_next[2] = 1'b0;
                    end
                end
            end

            lcdmt_pkg::CMD_READ:
            begin
                rhit_next = 1'b1;
                case (address)
                    lcdmt_pkg::ADDR_LCDC: rdata_next = ctrl_reg;
                    lcdmt_pkg::ADDR_STAT: rdata_next = stat_reg;
                    lcdmt_pkg::ADDR_SCY:  rdata_next = scy_reg;
                    lcdmt_pkg::ADDR_SCX:  rdata_next = scx_reg;
                    lcdmt_pkg::ADDR_LY:   rdata_next = line_reg;
                    lcdmt_pkg::ADDR_LYC:  rdata_next = lyc_reg;
                    lcdmt_pkg::ADDR_BGP:  rdata_next = bgp_reg;
                    lcdmt_pkg::ADDR_OBP0: rdata_next = obp0_reg;
                    lcdmt_pkg::ADDR_OBP1: rdata_next = obp1_reg;
                    lcdmt_pkg::ADDR_WY:   rdata_next = wy_reg;
                    lcdmt_pkg::ADDR_WX:   rdata_next = wx_reg;
                    lcdmt_pkg::ADDR_VBK:
                    begin
                        rhit_next  = color_mode_reg;
                        if (color_mode_reg)
                            rdata_next = lcdmt_pkg::BANK_READ_ONES | {7'd0, bank_reg};
                    end
                    lcdmt_pkg::ADDR_BCPS:
                    begin
                        rhit_next = color_mode_reg;
                        if (color_mode_reg)
                            rdata_next = bg_idx_reg;
                    end
                    lcdmt_pkg::ADDR_BCPD:
                    begin
                        // Data arrives from the RAM port in the output stage
                        rhit_next = color_mode_reg;
                        if (color_mode_reg)
                        begin
                            bg_re        = 1'b1;
                            src_next     = lcdmt_pkg::SRC_BG_PAL;
                            ent_vld_next = bg_vld_reg[bg_idx_reg[PAL_AW-1:0]];
                        end
                    end
                    lcdmt_pkg::ADDR_OCPS:
                    begin
                        rhit_next = color_mode_reg;
                        if (color_mode_reg)
                            rdata_next = obj_idx_reg;
                    end
                    lcdmt_pkg::ADDR_OCPD:
                    begin
                        rhit_next = color_mode_reg;
                        if (color_mode_reg)
                        begin
                            obj_re       = 1'b1;
                            src_next     = lcdmt_pkg::SRC_OBJ_PAL;
                            ent_vld_next = obj_vld_reg[obj_idx_reg[PAL_AW-1:0]];
                        end
                    end
                    default:              rhit_next = 1'b0;
                endcase
            end

            lcdmt_pkg::CMD_WRITE:
            begin
                whit_next = 1'b1;
                case (address)
                    lcdmt_pkg::ADDR_LCDC:
                    begin
                        // Display switched off: restart the line in hblank
                        if (ctrl_reg[7] && !write_data[7])
                        begin
                            line_next = 8'd0;
                            cnt_next  = '0;
                            mode_next = lcdmt_pkg::MODE_HBLANK;
                            stat_next = {stat_reg[7:2], 2'b00};
                        end
                        ctrl_next = write_data;
                    end
                    lcdmt_pkg::ADDR_STAT:
                        stat_next = (stat_reg & ~lcdmt_pkg::STAT_WRITE_MASK)
                                  | (write_data & lcdmt_pkg::STAT_WRITE_MASK);
                    lcdmt_pkg::ADDR_SCY:  scy_next  = write_data;
                    lcdmt_pkg::ADDR_SCX:  scx_next  = write_data;
                    lcdmt_pkg::ADDR_LY:   whit_next = 1'b1;
                    lcdmt_pkg::ADDR_LYC:  lyc_next  = write_data;
                    lcdmt_pkg::ADDR_BGP:  bgp_next  = write_data;
                    lcdmt_pkg::ADDR_OBP0: obp0_next = write_data;
                    lcdmt_pkg::ADDR_OBP1: obp1_next = write_data;
                    lcdmt_pkg::ADDR_WY:   wy_next   = write_data;
                    lcdmt_pkg::ADDR_WX:   wx_next   = write_data;
                    lcdmt_pkg::ADDR_VBK:
                    begin
                        whit_next = color_mode_reg;
                        if (color_mode_reg)
                            bank_next = write_data[0];
                    end
                    lcdmt_pkg::ADDR_BCPS:
                    begin
                        whit_next = color_mode_reg;
                        if (color_mode_reg)
                            bg_idx_next = write_data;
                    end
                    lcdmt_pkg::ADDR_BCPD:
                    begin
                        whit_next = color_mode_reg;
                        if (color_mode_reg)
                        begin
                            bg_we       = 1'b1;
                            bg_idx_next = lcdmt_pkg::next_index(bg_idx_reg);
                        end
                    end
                    lcdmt_pkg::ADDR_OCPS:
                    begin
                        whit_next = color_mode_reg;
                        if (color_mode_reg)
                            obj_idx_next = write_data;
                    end
                    lcdmt_pkg::ADDR_OCPD:
                    begin
                        whit_next = color_mode_reg;
                        if (color_mode_reg)
                        begin
                            obj_we       = 1'b1;
                            obj_idx_next = lcdmt_pkg::next_index(obj_idx_reg);
                        end
                    end
                    default:              whit_next = 1'b0;
                endcase
            end

            default:
            begin
                rhit_next = 1'b0;
            end
        endcase
    end

    // Palette RAMs: write and read both issue at the accepting edge
    lcdmt_ram #(
        .WIDTH (8),
        .DEPTH (PALETTE_BYTES)
    ) u_bg_pal (
        .clk   (clk),
        .we    (in_acc && bg_we),
        .waddr (bg_idx_reg[PAL_AW-1:0]),
        .wdata (write_data),
        .re    (in_acc && bg_re),
        .raddr (bg_idx_reg[PAL_AW-1:0]),
        .rdata (bg_q)
    );

    lcdmt_ram #(
        .WIDTH (8),
        .DEPTH (PALETTE_BYTES)
    ) u_obj_pal (
        .clk   (clk),
        .we    (in_acc && obj_we),
        .waddr (obj_idx_reg[PAL_AW-1:0]),
        .wdata (write_data),
        .re    (in_acc && obj_re),
        .raddr (obj_idx_reg[PAL_AW-1:0]),
        .rdata (obj_q)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg    <= 1'b0;
            scan_cycles_reg   <= lcdmt_pkg::SCAN_CYCLES_RST;
            draw_cycles_reg   <= lcdmt_pkg::DRAW_CYCLES_RST;
            line_cycles_reg   <= lcdmt_pkg::LINE_CYCLES_RST;
            visible_lines_reg <= lcdmt_pkg::VISIBLE_LINES_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lcdmt_pkg::CFG_COLOR_MODE:    color_mode_reg    <= cfg_data[0];
                lcdmt_pkg::CFG_SCAN_CYCLES:   scan_cycles_reg   <= cfg_data[8:0];
                lcdmt_pkg::CFG_DRAW_CYCLES:   draw_cycles_reg   <= cfg_data[8:0];
                lcdmt_pkg::CFG_LINE_CYCLES:   line_cycles_reg   <= cfg_data;
                lcdmt_pkg::CFG_VISIBLE_LINES: visible_lines_reg <= cfg_data[7:0];
                default:                      color_mode_reg    <= color_mode_reg;
            endcase
        end
    end

    // Timing and register state: advance on every accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            mode_reg    <= lcdmt_pkg::MODE_SCAN;
            line_reg    <= 8'd0;
            ctrl_reg    <= 8'd0;
            stat_reg    <= 8'd0;
            scy_reg     <= 8'd0;
            scx_reg     <= 8'd0;
            lyc_reg     <= 8'd0;
            bgp_reg     <= 8'd0;
            obp0_reg    <= 8'd0;
            obp1_reg    <= 8'd0;
            wy_reg      <= 8'd0;
            wx_reg      <= 8'd0;
            bank_reg    <= 1'b0;
            bg_idx_reg  <= 8'd0;
            obj_idx_reg <= 8'd0;
            bg_vld_reg  <= '0;
            obj_vld_reg <= '0;
        end
        else if (in_acc)
        begin
            cnt_reg     <= cnt_next;
            mode_reg    <= mode_next;
            line_reg    <= line_next;
            ctrl_reg    <= ctrl_next;
            stat_reg    <= stat_next;
            scy_reg     <= scy_next;
            scx_reg     <= scx_next;
            lyc_reg     <= lyc_next;
            bgp_reg     <= bgp_next;
            obp0_reg    <= obp0_next;
            obp1_reg    <= obp1_next;
            wy_reg      <= wy_next;
            wx_reg      <= wx_next;
            bank_reg    <= bank_next;
            bg_idx_reg  <= bg_idx_next;
            obj_idx_reg <= obj_idx_next;
            if (bg_we)
                bg_vld_reg[bg_idx_reg[PAL_AW-1:0]] <= 1'b1;
            if (obj_we)
                obj_vld_reg[obj_idx_reg[PAL_AW-1:0]] <= 1'b1;
        end
    end

    // Output stage: hold while stalled, load on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            rdata_reg   <= rdata_next;
            rhit_reg    <= rhit_next;
            whit_reg    <= whit_next;
            flags_reg   <= flags_next;
            src_reg     <= src_next;
            ent_vld_reg <= ent_vld_next;
        end
    end

    // Pick the read data; palette RAM outputs hold until the next palette read
    always_comb
    begin
        case (src_reg)
            lcdmt_pkg::SRC_BG_PAL:  read_data = ent_vld_reg ? bg_q : 8'd0;
            lcdmt_pkg::SRC_OBJ_PAL: read_data = ent_vld_reg ? obj_q : 8'd0;
            default:                read_data = rdata_reg;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign read_hit       = rhit_reg;
    assign write_hit      = whit_reg;
    assign vblank_request = flags_reg.vblank;
    assign status_request = flags_reg.stat;
    assign frame_done     = flags_reg.frame;
    assign hblank_entered = flags_reg.hblank;
    assign current_mode   = mode_reg;
    assign current_line   = line_reg;

    // After a tick with the display on, STAT mode bits follow the mode
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && command == lcdmt_pkg::CMD_TICK && ctrl_reg[7])
        |=> (stat_reg[1:0] == mode_reg))
        else $error("STAT mode bits out of step with mode");

    // With the display off, a tick leaves the counter below one frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && command == lcdmt_pkg::CMD_TICK && !ctrl_reg[7])
        |=> (cnt_reg < lcdmt_pkg::FRAME_CYCLES))
        else $error("frame counter not wrapped");

    // Auto-increment of the background index clears bit 6
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && bg_we && bg_idx_reg[7]) |=> (!bg_idx_reg[6] && bg_idx_reg[7]))
        else $error("background palette index increment broken");

    // A result never hits on both a read and a write
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(rhit_reg && whit_reg))
        else $error("read and write hit together");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 400000;

    // One report per request: read side, hits, pending flags, mode and line
    typedef struct {
        logic [7:0]        data;
        logic              rd_hit;
        logic              wr_hit;
        lcdmt_pkg::flags_t flags;
        lcdmt_pkg::mode_t  md;
        logic [7:0]        ly;
    } lcd_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic             cfg_write = 1'b0;
    logic [2:0]       cfg_index = '0;
    logic [lcdmt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  command = '0;
    logic [15:0] address = '0;
    logic [7:0]  write_data = '0;
    logic [7:0]  tick_cycles = '0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  read_data;
    logic        read_hit;
    logic        write_hit;
    logic        vblank_request;
    logic        status_request;
    logic        frame_done;
    logic        hblank_entered;
    logic [1:0]  current_mode;
    logic [7:0]  current_line;

    // Shadow of the block: timing settings
    logic       m_colour = 1'b0;
    logic [8:0] m_scan = lcdmt_pkg::SCAN_CYCLES_RST;
    logic [8:0] m_draw = lcdmt_pkg::DRAW_CYCLES_RST;
    logic [9:0] m_line_len = lcdmt_pkg::LINE_CYCLES_RST;
    logic [7:0] m_vis = lcdmt_pkg::VISIBLE_LINES_RST;

    // Shadow of the block: timing state and register file
    logic [16:0]       m_count = '0;
    lcdmt_pkg::mode_t  m_mode = lcdmt_pkg::MODE_SCAN;
    logic [7:0]        m_ly = '0;
    logic [7:0]        m_ctrl = '0;
    logic [7:0]        m_stat = '0;
    logic [7:0]        m_scy = '0;
    logic [7:0]        m_scx = '0;
    logic [7:0]        m_lyc = '0;
    logic [7:0]        m_bgp = '0;
    logic [7:0]        m_obp0 = '0;
    logic [7:0]        m_obp1 = '0;
    logic [7:0]        m_wy = '0;
    logic [7:0]        m_wx = '0;
    logic              m_bank = 1'b0;
    logic [7:0]        m_bg_idx = '0;
    logic [7:0]        m_obj_idx = '0;
    logic [7:0]        m_bg_pal [lcdmt_pkg::PALETTE_BYTES_DEF];
    logic [7:0]        m_obj_pal [lcdmt_pkg::PALETTE_BYTES_DEF];
    lcdmt_pkg::flags_t m_flags = '0;

    lcd_report_t lcd_report_q [$];

    int  errors = 0;
    int  cycle_no = 0;
    int  stall_left = 0;
    bit  idle_on = 1'b1;

    lcd_mode_timing_and_status_registers u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .address        (address),
        .write_data     (write_data),
        .tick_cycles    (tick_cycles),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_data      (read_data),
        .read_hit       (read_hit),
        .write_hit      (write_hit),
        .vblank_request (vblank_request),
        .status_request (status_request),
        .frame_done     (frame_done),
        .hblank_entered (hblank_entered),
        .current_mode   (current_mode),
        .current_line   (current_line)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Guard against a hung handshake: bail out well past the slowest good run
    always @(posedge clk)
    begin
        cycle_no++;
        if (cycle_no > CYCLE_LIMIT)
        begin
            $display("lcd_mode_timing_and_status_registers test failed");
            $finish;
        end
    end

    // Idle cycles for one request or one report, 0 in a no-idle stretch
    function automatic int draw_idle();
        return idle_on ? int'($urandom_range(0, 6)) : 0;
    endfunction

    // Apply one accepted request to the shadow and queue the report it owes.
    // Everything lands at the accepting edge, so run this in acceptance order.
    task automatic predict_lcd_report(lcdmt_pkg::cmd_t c, logic [15:0] a,
                                      logic [7:0] d, logic [7:0] t);
        lcd_report_t rep;
        int          total;
        rep.data   = 8'd0;
        rep.rd_hit = 1'b0;
        rep.wr_hit = 1'b0;
        case (c)
            lcdmt_pkg::CMD_TICK:
            begin
                total = int'(m_count) + int'(t);
                if (total > int'(lcdmt_pkg::COUNT_MAX))
                    total = int'(lcdmt_pkg::COUNT_MAX);
                if (!m_ctrl[7])
                begin
                    // Display off: only measure whole frames
                    if (total >= int'(lcdmt_pkg::FRAME_CYCLES))
                    begin
                        total -= int'(lcdmt_pkg::FRAME_CYCLES);
                        m_flags.frame = 1'b1;
                    end
                    m_count = total[16:0];
                end
                else
                begin
                    // At most one mode step per tick
                    case (m_mode)
                        lcdmt_pkg::MODE_SCAN:
                            if (total >= int'(m_scan))
                                m_mode = lcdmt_pkg::MODE_DRAW;
                        lcdmt_pkg::MODE_DRAW:
                            if (total >= int'(m_scan) + int'(m_draw))
                            begin
                                m_mode = lcdmt_pkg::MODE_HBLANK;
                                m_flags.hblank = 1'b1;
                                if (m_stat[3])
                                    m_flags.stat = 1'b1;
                            end
                        lcdmt_pkg::MODE_HBLANK:
                            if (total >= int'(m_line_len))
                            begin
                                total -= int'(m_line_len);
                                m_ly = m_ly + 8'd1;
                                if (m_ly == m_vis)
                                begin
                                    m_mode = lcdmt_pkg::MODE_VBLANK;
                                    m_flags.vblank = 1'b1;
                                    if (m_stat[4])
                                        m_flags.stat = 1'b1;
                                end
                                else
                                begin
                                    m_mode = lcdmt_pkg::MODE_SCAN;
                                    if (m_stat[5])
                                        m_flags.stat = 1'b1;
                                end
                            end
                        default:
                            if (total >= int'(m_line_len))
                            begin
                                total -= int'(m_line_len);
                                m_ly = m_ly + 8'd1;
                                if (m_ly > lcdmt_pkg::LAST_LINE)
                                begin
                                    m_ly = 8'd0;
                                    m_mode = lcdmt_pkg::MODE_SCAN;
                                    m_flags.frame = 1'b1;
                                    if (m_stat[5])
                                        m_flags.stat = 1'b1;
                                end
                            end
                    endcase
                    m_count = total[16:0];
                    m_stat[1:0] = m_mode;
                    if (m_ly == m_lyc)
                    begin
                        m_stat[2] = 1'b1;
                        if (m_stat[6])
                            m_flags.stat = 1'b1;
                    end
                    else
                        m_stat[2] = 1'b0;
                end
            end
            lcdmt_pkg::CMD_READ:
            begin
                rep.rd_hit = 1'b1;
                case (a)
                    lcdmt_pkg::ADDR_LCDC: rep.data = m_ctrl;
                    lcdmt_pkg::ADDR_STAT: rep.data = m_stat;
                    lcdmt_pkg::ADDR_SCY:  rep.data = m_scy;
                    lcdmt_pkg::ADDR_SCX:  rep.data = m_scx;
                    lcdmt_pkg::ADDR_LY:   rep.data = m_ly;
                    lcdmt_pkg::ADDR_LYC:  rep.data = m_lyc;
                    lcdmt_pkg::ADDR_BGP:  rep.data = m_bgp;
                    lcdmt_pkg::ADDR_OBP0: rep.data = m_obp0;
                    lcdmt_pkg::ADDR_OBP1: rep.data = m_obp1;
                    lcdmt_pkg::ADDR_WY:   rep.data = m_wy;
                    lcdmt_pkg::ADDR_WX:   rep.data = m_wx;
                    lcdmt_pkg::ADDR_VBK:
                        rep.data = lcdmt_pkg::BANK_READ_ONES | {7'd0, m_bank};
                    lcdmt_pkg::ADDR_BCPS: rep.data = m_bg_idx;
                    lcdmt_pkg::ADDR_BCPD: rep.data = m_bg_pal[m_bg_idx[5:0]];
                    lcdmt_pkg::ADDR_OCPS: rep.data = m_obj_idx;
                    lcdmt_pkg::ADDR_OCPD: rep.data = m_obj_pal[m_obj_idx[5:0]];
                    default:              rep.rd_hit = 1'b0;
                endcase
                // Colour registers vanish from the map in mono mode
                if (!m_colour && (a == lcdmt_pkg::ADDR_VBK || a == lcdmt_pkg::ADDR_BCPS ||
                                  a == lcdmt_pkg::ADDR_BCPD || a == lcdmt_pkg::ADDR_OCPS ||
                                  a == lcdmt_pkg::ADDR_OCPD))
                    rep.rd_hit = 1'b0;
                if (!rep.rd_hit)
                    rep.data = 8'd0;
            end
            lcdmt_pkg::CMD_WRITE:
            begin
                rep.wr_hit = 1'b1;
                case (a)
                    lcdmt_pkg::ADDR_LCDC:
                    begin
                        // Switching the display off parks the timing at line 0, hblank
                        if (m_ctrl[7] && !d[7])
                        begin
                            m_ly = 8'd0;
                            m_count = '0;
                            m_mode = lcdmt_pkg::MODE_HBLANK;
                            m_stat[1:0] = 2'b00;
                        end
                        m_ctrl = d;
                    end
                    lcdmt_pkg::ADDR_STAT:
                        m_stat = (m_stat & 8'h07) | (d & lcdmt_pkg::STAT_WRITE_MASK);
                    lcdmt_pkg::ADDR_SCY:  m_scy = d;
                    lcdmt_pkg::ADDR_SCX:  m_scx = d;
                    lcdmt_pkg::ADDR_LY:   ;
                    lcdmt_pkg::ADDR_LYC:  m_lyc = d;
                    lcdmt_pkg::ADDR_BGP:  m_bgp = d;
                    lcdmt_pkg::ADDR_OBP0: m_obp0 = d;
                    lcdmt_pkg::ADDR_OBP1: m_obp1 = d;
                    lcdmt_pkg::ADDR_WY:   m_wy = d;
                    lcdmt_pkg::ADDR_WX:   m_wx = d;
                    lcdmt_pkg::ADDR_VBK:
                        if (m_colour) m_bank = d[0]; else rep.wr_hit = 1'b0;
                    lcdmt_pkg::ADDR_BCPS:
                        if (m_colour) m_bg_idx = d; else rep.wr_hit = 1'b0;
                    lcdmt_pkg::ADDR_OCPS:
                        if (m_colour) m_obj_idx = d; else rep.wr_hit = 1'b0;
                    lcdmt_pkg::ADDR_BCPD:
                        if (m_colour)
                        begin
                            m_bg_pal[m_bg_idx[5:0]] = d;
                            if (m_bg_idx[7])
                                m_bg_idx = {2'b10, m_bg_idx[5:0] + 6'd1};
                        end
                        else
                            rep.wr_hit = 1'b0;
                    lcdmt_pkg::ADDR_OCPD:
                        if (m_colour)
                        begin
                            m_obj_pal[m_obj_idx[5:0]] = d;
                            if (m_obj_idx[7])
                                m_obj_idx = {2'b10, m_obj_idx[5:0] + 6'd1};
                        end
                        else
                            rep.wr_hit = 1'b0;
                    default: rep.wr_hit = 1'b0;
                endcase
            end
            default: ;
        endcase
        // Report the flags raised so far, then clear them
        rep.flags = m_flags;
        rep.md    = m_mode;
        rep.ly    = m_ly;
        m_flags   = '0;
        lcd_report_q.push_back(rep);
    endtask

    // Offer one request; hold valid and payload until accepted. Valid is left
    // high so a back-to-back request needs no drop in between.
    task automatic send_request(lcdmt_pkg::cmd_t c, logic [15:0] a,
                                logic [7:0] d, logic [7:0] t);
        int gap;
        gap = draw_idle();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= c;
        address     <= a;
        write_data  <= d;
        tick_cycles <= t;
        do
            @(posedge clk);
        while (!in_ready);
        predict_lcd_report(c, a, d, t);
    endtask

    // Drop valid and wait until every outstanding report has come back
    task automatic drain_reports();
        in_valid <= 1'b0;
        while (lcd_report_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_config(logic [2:0] idx, int unsigned val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[lcdmt_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            lcdmt_pkg::CFG_COLOR_MODE:    m_colour = val[0];
            lcdmt_pkg::CFG_SCAN_CYCLES:   m_scan = val[8:0];
            lcdmt_pkg::CFG_DRAW_CYCLES:   m_draw = val[8:0];
            lcdmt_pkg::CFG_LINE_CYCLES:   m_line_len = val[9:0];
            lcdmt_pkg::CFG_VISIBLE_LINES: m_vis = val[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Settle the block, then load all five settings
    task automatic apply_timing(int unsigned colour, int unsigned scan, int unsigned draw,
                                int unsigned line_len, int unsigned vis);
        drain_reports();
        set_config(lcdmt_pkg::CFG_COLOR_MODE, colour);
        set_config(lcdmt_pkg::CFG_SCAN_CYCLES, scan);
        set_config(lcdmt_pkg::CFG_DRAW_CYCLES, draw);
        set_config(lcdmt_pkg::CFG_LINE_CYCLES, line_len);
        set_config(lcdmt_pkg::CFG_VISIBLE_LINES, vis);
    endtask

    // Random traffic: mostly ticks to push the timing along, register reads and
    // writes on the map, and some noise on random addresses and commands.
    // Keep the display on unless allow_off; pause once for a full drain midway.
    task automatic run_traffic(int count, int tick_pct, bit allow_off);
        int              k;
        int              r;
        lcdmt_pkg::cmd_t c;
        logic [15:0]     a;
        logic [7:0]      d;
        logic [7:0]      t;
        for (k = 0; k < count; k++)
        begin
            if (k % 50 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (k == count / 2)
                drain_reports();
            a = 16'($urandom_range(0, 65535));
            d = 8'($urandom_range(0, 255));
            t = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0)
                t = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            r = $urandom_range(0, 99);
            if (r < tick_pct)
                c = lcdmt_pkg::CMD_TICK;
            else if (r < tick_pct + (100 - tick_pct) * 8 / 10)
            begin
                c = $urandom_range(0, 1) ? lcdmt_pkg::CMD_WRITE : lcdmt_pkg::CMD_READ;
                case ($urandom_range(0, 15))
                    0:  a = lcdmt_pkg::ADDR_LCDC;
                    1:  a = lcdmt_pkg::ADDR_STAT;
                    2:  a = lcdmt_pkg::ADDR_SCY;
                    3:  a = lcdmt_pkg::ADDR_SCX;
                    4:  a = lcdmt_pkg::ADDR_LY;
                    5:  a = lcdmt_pkg::ADDR_LYC;
                    6:  a = lcdmt_pkg::ADDR_BGP;
                    7:  a = lcdmt_pkg::ADDR_OBP0;
                    8:  a = lcdmt_pkg::ADDR_OBP1;
                    9:  a = lcdmt_pkg::ADDR_WY;
                    10: a = lcdmt_pkg::ADDR_WX;
                    11: a = lcdmt_pkg::ADDR_VBK;
                    12: a = lcdmt_pkg::ADDR_BCPS;
                    13: a = lcdmt_pkg::ADDR_BCPD;
                    14: a = lcdmt_pkg::ADDR_OCPS;
                    default: a = lcdmt_pkg::ADDR_OCPD;
                endcase
                // Small compare values so the coincidence bit actually fires
                if (a == lcdmt_pkg::ADDR_LYC && $urandom_range(0, 1) == 0)
                    d = m_ly + 8'($urandom_range(0, 2));
                if (c == lcdmt_pkg::CMD_WRITE && a == lcdmt_pkg::ADDR_LCDC &&
                    (!allow_off || $urandom_range(0, 5) != 0))
                    d[7] = 1'b1;
            end
            else
                c = lcdmt_pkg::cmd_t'($urandom_range(0, 3));
            send_request(c, a, d, t);
        end
        drain_reports();
    endtask

    // Registers straight out of reset, mono-mode misses, unused command,
    // read-only status bits, ignored line write, display on and off
    task automatic test_reset_state();
        send_request(lcdmt_pkg::CMD_READ, lcdmt_pkg::ADDR_LCDC, 8'h00, 8'h00);
        send_request(lcdmt_pkg::CMD_READ, lcdmt_pkg::ADDR_STAT, 8'h00, 8'h00);
        send_request(lcdmt_pkg::CMD_NONE, lcdmt_pkg::ADDR_LCDC, 8'hFF, 8'hFF);
        send_request(lcdmt_pkg::CMD_WRITE, 16'h0000, 8'hFF, 8'h00);
        send_request(lcdmt_pkg::CMD_READ, 16'hFFFF, 8'h00, 8'h00);
        send_request(lcdmt_pkg::CMD_WRITE, lcdmt_pkg::ADDR_VBK, 8'h01, 8'h00);
        send_request(lcdmt_pkg::CMD_READ, lcdmt_pkg::ADDR_BCPD, 8'h00, 8'h00);
        send_request(lcdmt_pkg::CMD_WRITE, lcdmt_pkg::ADDR_STAT, 8'hFF, 8'h00);
        send_request(lcdmt_pkg::CMD_READ, lcdmt_pkg::ADDR_STAT, 8'h00, 8'h00);
        send_request(lcdmt_pkg::CMD_WRITE, lcdmt_pkg::ADDR_LY, 8'h55, 8'h00);
        send_request(lcdmt_pkg::CMD_TICK, 16'h0000, 8'h00, 8'hFF);
        send_request(lcdmt_pkg::CMD_WRITE, lcdmt_pkg::ADDR_LCDC, 8'h80, 8'h00);
        send_request(lcdmt_pkg::CMD_TICK, 16'h0000, 8'h00, 8'h00);
        send_request(lcdmt_pkg::CMD_TICK, 16'h0000, 8'h00, 8'hFF);
        send_request(lcdmt_pkg::CMD_TICK, 16'h0000, 8'h00, 8'hFF);
        send_request(lcdmt_pkg::CMD_READ, lcdmt_pkg::ADDR_STAT, 8'h00, 8'h00);
        send_request(lcdmt_pkg::CMD_WRITE, lcdmt_pkg::ADDR_LCDC, 8'h00, 8'h00);
        send_request(lcdmt_pkg::CMD_TICK, 16'h0000, 8'h00, 8'hFF);
        drain_reports();
    endtask

    // Colour registers: index auto-increment wrapping at the top with bit 6
    // dropped, plain index, palette data, bank readback with the ones above
    task automatic test_colour_registers();
        set_config(lcdmt_pkg::CFG_COLOR_MODE, 1);
        send_request(lcdmt_pkg::CMD_WRITE, lcdmt_pkg::ADDR_BCPS, 8'hFF, 8'h00);
        send_request(lcdmt_pkg::CMD_WRITE, lcdmt_pkg::ADDR_BCPD, 8'hA5, 8'h00);
        send_request(lcdmt_pkg::CMD_READ, lcdmt_pkg::ADDR_BCPS, 8'h00, 8'h00);
        send_request(lcdmt_pkg::CMD_READ, lcdmt_pkg::ADDR_BCPD, 8'h00, 8'h00);
        send_request(lcdmt_pkg::CMD_WRITE, lcdmt_pkg::ADDR_OCPS, 8'h3F, 8'h00);
        send_request(lcdmt_pkg::CMD_WRITE, lcdmt_pkg::ADDR_OCPD, 8'h5A, 8'h00);
        send_request(lcdmt_pkg::CMD_READ, lcdmt_pkg::ADDR_OCPD, 8'h00, 8'h00);
        send_request(lcdmt_pkg::CMD_READ, lcdmt_pkg::ADDR_OCPS, 8'h00, 8'h00);
        send_request(lcdmt_pkg::CMD_WRITE, lcdmt_pkg::ADDR_VBK, 8'hFF, 8'h00);
        send_request(lcdmt_pkg::CMD_READ, lcdmt_pkg::ADDR_VBK, 8'h00, 8'h00);
        drain_reports();
    endtask

    task automatic test_default_timing();
        apply_timing(1, 32'(lcdmt_pkg::SCAN_CYCLES_RST), 32'(lcdmt_pkg::DRAW_CYCLES_RST),
                     32'(lcdmt_pkg::LINE_CYCLES_RST), 32'(lcdmt_pkg::VISIBLE_LINES_RST));
        send_request(lcdmt_pkg::CMD_WRITE, lcdmt_pkg::ADDR_LCDC, 8'h91, 8'h00);
        run_traffic(200, 60, 1'b1);
    endtask

    // Longest line and draw, all 153 lines visible
    task automatic test_long_lines();
        apply_timing(0, 1, 511, 1023, 153);
        send_request(lcdmt_pkg::CMD_WRITE, lcdmt_pkg::ADDR_LCDC, 8'h80, 8'h00);
        run_traffic(150, 65, 1'b1);
    endtask

    // Scan longer than the whole line, vblank right after the first line
    task automatic test_slow_scan();
        apply_timing(1, 511, 1, 1, 1);
        send_request(lcdmt_pkg::CMD_WRITE, lcdmt_pkg::ADDR_LCDC, 8'h80, 8'h00);
        run_traffic(150, 65, 1'b1);
    endtask

    // Run the line past the vblank start so it wraps from 255 to 0; with
    // a line length of 1, the counter outgrows each subtract and saturates
    task automatic test_line_wrap();
        apply_timing(0, 1, 1, 1, 153);
        send_request(lcdmt_pkg::CMD_WRITE, lcdmt_pkg::ADDR_LCDC, 8'h00, 8'h00);
        send_request(lcdmt_pkg::CMD_WRITE, lcdmt_pkg::ADDR_LCDC, 8'h80, 8'h00);
        while (m_ly < 8'd3)
            send_request(lcdmt_pkg::CMD_TICK, 16'h0000, 8'h00, 8'd200);
        drain_reports();
        set_config(lcdmt_pkg::CFG_VISIBLE_LINES, 2);
        run_traffic(1000, 88, 1'b0);
    endtask

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Pace the result side: draw a stall after each accepted report
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            stall_left = draw_idle();
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
            out_ready <= 1'b1;
    end

    // Match every accepted report against the oldest prediction
    always @(posedge clk)
    begin : check_reports
        lcd_report_t rep;
        if (rst_n && out_valid && out_ready)
        begin
            if (lcd_report_q.size() == 0)
            begin
                errors++;
                $display("%0t: report with no request outstanding, expected none, actual line %0d",
                         $time, current_line);
            end
            else
            begin
                rep = lcd_report_q.pop_front();
                check_field("read_data", rep.data, read_data);
                check_field("read_hit", 8'(rep.rd_hit), 8'(read_hit));
                check_field("write_hit", 8'(rep.wr_hit), 8'(write_hit));
                check_field("vblank_request", 8'(rep.flags.vblank), 8'(vblank_request));
                check_field("status_request", 8'(rep.flags.stat), 8'(status_request));
                check_field("frame_done", 8'(rep.flags.frame), 8'(frame_done));
                check_field("hblank_entered", 8'(rep.flags.hblank), 8'(hblank_entered));
                check_field("current_mode", 8'(rep.md), 8'(current_mode));
                check_field("current_line", rep.ly, current_line);
            end
        end
    end

    initial
    begin
        foreach (m_bg_pal[i])
        begin
            m_bg_pal[i]  = 8'h00;
            m_obj_pal[i] = 8'h00;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_colour_registers();
        test_default_timing();
        test_long_lines();
        test_slow_scan();
        test_line_wrap();

        drain_reports();
        if (errors == 0 && lcd_report_q.size() == 0)
            $display("lcd_mode_timing_and_status_registers test passed");
        else
            $display("lcd_mode_timing_and_status_registers test failed");
        $finish;
    end

endmodule
